// ===== rtl/core/ffba_pkg.sv =====
// Shared types and constants for the first-fit block allocator.
// Used by ffba_cell and first_fit_block_allocator_core; no dependencies.
package ffba_pkg;

    localparam int HEAP_BYTES_DEF   = 1048576;
    localparam int MAX_BLOCKS_DEF   = 64;
    localparam int HEADER_BYTES_DEF = 24;

    localparam int ADDR_W   = 48;
    localparam int SIZE_W   = 21;
    localparam int STATUS_W = 3;

    localparam logic [ADDR_W-1:0] BASE_RESET = 48'h0000_0040_0000;

    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED = 3'd0,
        ST_NO_FIT  = 3'd1,
        ST_FREED   = 3'd2,
        ST_NULL    = 3'd3,
        ST_UNKNOWN = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_ALLOC,
        OP_SETFREE,
        OP_MERGE
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     split;
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_ACT,
        S_MERGE_R,
        S_MERGE_L,
        S_DONE
    } t_state;

endpackage

// ===== rtl/core/ffba_cell.sv =====
// One entry of the block table: start, size, free and valid flags.
// Shifts toward neighbors on insert and merge; depends on ffba_pkg.
module ffba_cell #(
    parameter int AW          = 20,
    parameter int IW          = 6,
    parameter int IDX         = 0,
    parameter int HEAP_BYTES  = ffba_pkg::HEAP_BYTES_DEF,
    parameter int HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ffba_pkg::t_cmd        i_cmd,
    input  logic [IW-1:0]         i_idx,
    input  logic [AW+1:0]         i_sz,
    input  logic [AW-1:0]         i_tgt,
    input  logic                  i_tgt_ok,
    input  logic [AW-1:0]         i_l_start,
    input  logic [AW-1:0]         i_l_bytes,
    input  logic                  i_l_free,
    input  logic                  i_l_valid,
    input  logic [AW-1:0]         i_r_start,
    input  logic [AW-1:0]         i_r_bytes,
    input  logic                  i_r_free,
    input  logic                  i_r_valid,
    output logic [AW-1:0]         o_start,
    output logic [AW-1:0]         o_bytes,
    output logic                  o_free,
    output logic                  o_valid,
    output logic                  o_fit,
    output logic                  o_split,
    output logic                  o_hit
);

    localparam logic [IW:0]   MY_IDX   = (IW+1)'(IDX);
    localparam logic [AW+2:0] HDR      = (AW+3)'(HEADER_BYTES);
    localparam logic [AW-1:0] BYTES_R  = AW'(HEAP_BYTES - HEADER_BYTES);

    logic [AW-1:0] r_start, n_start;
    logic [AW-1:0] r_bytes, n_bytes;
    logic          r_free, n_free;
    logic          r_valid, n_valid;

    logic          sel, nxt, after;
    logic [AW+2:0] sum_new, sum_rem, sum_mrg;

    always_comb begin
        sel   = ({1'b0, i_idx} == MY_IDX);
        nxt   = ({1'b0, i_idx} + 1'b1 == MY_IDX);
        after = ({1'b0, i_idx} < MY_IDX);
        sum_new = (AW+3)'(i_l_start) + HDR + (AW+3)'(i_sz);
        sum_rem = (AW+3)'(i_l_bytes) - (AW+3)'(i_sz) - HDR;
        sum_mrg = (AW+3)'(r_bytes) + HDR + (AW+3)'(i_r_bytes);

        o_fit   = r_valid & r_free & ((AW+2)'(r_bytes) >= i_sz);
        o_split = (AW+3)'(r_bytes) > ((AW+3)'(i_sz) + HDR + (AW+3)'(8));
        o_hit   = r_valid & i_tgt_ok & (r_start == i_tgt);

        n_start = r_start;
        n_bytes = r_bytes;
        n_free  = r_free;
        n_valid = r_valid;
        case (i_cmd.op)
            ffba_pkg::OP_ALLOC: begin
                if (sel) begin
                    if (i_cmd.split) begin
                        n_bytes = i_sz[AW-1:0];
                    end
                    n_free  = 1'b0;
                end else if (i_cmd.split && nxt) begin
                    n_start = sum_new[AW-1:0];
                    n_bytes = sum_rem[AW-1:0];
                    n_free  = 1'b1;
                    n_valid = 1'b1;
                end else if (i_cmd.split && after) begin
                    n_start = i_l_start;
                    n_bytes = i_l_bytes;
                    n_free  = i_l_free;
                    n_valid = i_l_valid;
                end
            end
            ffba_pkg::OP_SETFREE: begin
                if (sel) begin
                    n_free = 1'b1;
                end
            end
            ffba_pkg::OP_MERGE: begin
                if (sel) begin
                    n_bytes = sum_mrg[AW-1:0];
                end else if (after) begin
                    n_start = i_r_start;
                    n_bytes = i_r_bytes;
                    n_free  = i_r_free;
                    n_valid = i_r_valid;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
            r_bytes <= (IDX == 0) ? BYTES_R : '0;
            r_free  <= (IDX == 0);
            r_valid <= (IDX == 0);
        end else begin
            r_start <= n_start;
            r_bytes <= n_bytes;
            r_free  <= n_free;
            r_valid <= n_valid;
        end
    end

    assign o_start = r_start;
    assign o_bytes = r_bytes;
    assign o_free  = r_free;
    assign o_valid = r_valid;

endmodule

// ===== rtl/core/first_fit_block_allocator_core.sv =====
// First-fit heap allocator top level: controller over a row of ffba_cell entries.
// Zero size or null free go straight to the result; allocate or unknown address
// take find and act first, a successful free find, mark, merge right and merge left.
// Throughput: one word at a time; the next is accepted only after the last has reached
// the output register, which waits out any output stall; the cell row sets the rate.
// Synchronous active-low reset restores a single free block covering the arena.
module first_fit_block_allocator_core #(
    parameter int HEAP_BYTES   = ffba_pkg::HEAP_BYTES_DEF,
    parameter int MAX_BLOCKS   = ffba_pkg::MAX_BLOCKS_DEF,
    parameter int HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ffba_pkg::ADDR_W-1:0]   i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_mode,
    input  logic [ffba_pkg::SIZE_W-1:0]   i_request_size,
    input  logic [ffba_pkg::ADDR_W-1:0]   i_free_address,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [ffba_pkg::ADDR_W-1:0]   o_address,
    output logic [ffba_pkg::STATUS_W-1:0] o_status
);

    localparam int AW = $clog2(HEAP_BYTES);
    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int DW = ffba_pkg::ADDR_W;
    localparam logic [DW-1:0] HDR = DW'(HEADER_BYTES);
    localparam int SIZE_W_P1 = ffba_pkg::SIZE_W + 1;

    ffba_pkg::t_state r_state, n_state;

    logic [DW-1:0]      r_base;
    logic               r_mode;
    logic [AW+1:0]      r_sz;
    logic [IW-1:0]      r_k, n_k;
    logic [MAX_BLOCKS-1:0] r_fit, r_split, r_hit;
    logic [DW-1:0]      r_res_addr, n_res_addr;
    logic [ffba_pkg::STATUS_W-1:0] r_res_status, n_res_status;
    logic               r_out_valid;
    logic [DW-1:0]      r_out_addr;
    logic [ffba_pkg::STATUS_W-1:0] r_out_status;

    ffba_pkg::t_cmd     cmd;
    logic [IW-1:0]      cmd_idx;

    logic [AW-1:0]      c_start [MAX_BLOCKS];
    logic [AW-1:0]      c_bytes [MAX_BLOCKS];
    logic [MAX_BLOCKS-1:0] c_free, c_valid, c_fit, c_split, c_hit;

    logic [MAX_BLOCKS-1:0] vec, first;
    logic [IW-1:0]      first_idx;
    logic [AW-1:0]      first_start;
    logic [IW:0]        k_next;

    logic               accept;
    logic [SIZE_W_P1-1:0] sz_round;
    logic               load_out;

    assign accept      = i_in_valid && (r_state == ffba_pkg::S_IDLE);
    assign o_in_stall  = (r_state != ffba_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign sz_round    = (SIZE_W_P1'(i_request_size) + SIZE_W_P1'(7)) & ~SIZE_W_P1'(7);

    always_comb begin
        vec = r_mode ? r_hit : r_fit;
        first = vec & (~vec + MAX_BLOCKS'(1));
        first_idx = '0;
        first_start = '0;
        for (int j = 0; j < MAX_BLOCKS; j++) begin
            if (first[j]) begin
                first_idx   = first_idx | IW'(j);
                first_start = first_start | c_start[j];
            end
        end
        k_next = {1'b0, r_k} + 1'b1;
    end

    always_comb begin
        n_state      = r_state;
        n_k          = r_k;
        n_res_addr   = r_res_addr;
        n_res_status = r_res_status;
        cmd.op       = ffba_pkg::OP_NONE;
        cmd.split    = 1'b0;
        cmd_idx      = r_k;
        load_out     = 1'b0;
        unique case (r_state)
            ffba_pkg::S_IDLE: begin
                if (accept) begin
                    n_res_addr = '0;
                    if (!i_mode && i_request_size == '0) begin
                        n_res_status = ffba_pkg::ST_NO_FIT;
                        n_state = ffba_pkg::S_DONE;
                    end else if (i_mode && i_free_address == '0) begin
                        n_res_status = ffba_pkg::ST_NULL;
                        n_state = ffba_pkg::S_DONE;
                    end else begin
                        n_state = ffba_pkg::S_FIND;
                    end
                end
            end
            ffba_pkg::S_FIND: begin
                n_state = ffba_pkg::S_ACT;
            end
            ffba_pkg::S_ACT: begin
                cmd_idx = first_idx;
                n_k = first_idx;
                if (vec == '0) begin
                    n_res_status = r_mode ? ffba_pkg::ST_UNKNOWN : ffba_pkg::ST_NO_FIT;
                    n_state = ffba_pkg::S_DONE;
                end else if (!r_mode) begin
                    cmd.op = ffba_pkg::OP_ALLOC;
                    cmd.split = |(first & r_split) && !c_valid[MAX_BLOCKS-1];
                    n_res_addr = r_base + DW'(first_start) + HDR;
                    n_res_status = ffba_pkg::ST_GRANTED;
                    n_state = ffba_pkg::S_DONE;
                end else begin
                    cmd.op = ffba_pkg::OP_SETFREE;
                    n_res_status = ffba_pkg::ST_FREED;
                    n_state = ffba_pkg::S_MERGE_R;
                end
            end
            ffba_pkg::S_MERGE_R: begin
                if (k_next < (IW+1)'(MAX_BLOCKS)) begin
                    if (c_valid[k_next[IW-1:0]] && c_free[k_next[IW-1:0]]) begin
                        cmd.op = ffba_pkg::OP_MERGE;
                    end
                end
                n_state = ffba_pkg::S_MERGE_L;
            end
            ffba_pkg::S_MERGE_L: begin
                cmd_idx = r_k - 1'b1;
                if (r_k != '0 && c_free[r_k - 1'b1]) begin
                    cmd.op = ffba_pkg::OP_MERGE;
                end
                n_state = ffba_pkg::S_DONE;
            end
            ffba_pkg::S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    load_out = 1'b1;
                    n_state = ffba_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ffba_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ffba_pkg::S_IDLE;
            r_base      <= ffba_pkg::BASE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_base <= i_cfg_data;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_k          <= n_k;
        r_res_addr   <= n_res_addr;
        r_res_status <= n_res_status;
        if (accept) begin
            r_mode <= i_mode;
            r_sz   <= sz_round[AW+1:0] | {1'b0, |sz_round[SIZE_W_P1-1:AW+1], AW'(0)};
        end
        if (r_state == ffba_pkg::S_FIND) begin
            r_fit   <= c_fit;
            r_split <= c_split;
            r_hit   <= c_hit;
        end
        if (load_out) begin
            r_out_addr   <= r_res_addr;
            r_out_status <= r_res_status;
        end
    end

    logic [DW-1:0] r_free_addr;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_free_addr <= i_free_address;
        end
    end

    logic [DW-1:0] tgt_calc;
    assign tgt_calc = r_free_addr - r_base - HDR;

    logic [AW-1:0] tgt_c;
    logic          tgt_ok_c;
    assign tgt_c    = tgt_calc[AW-1:0];
    assign tgt_ok_c = (tgt_calc[DW-1:AW] == '0);

    genvar g;
    generate
        for (g = 0; g < MAX_BLOCKS; g++) begin : g_cell
            logic [AW-1:0] l_start, l_bytes, rt_start, rt_bytes;
            logic          l_free, l_valid, rt_free, rt_valid;
            if (g == 0) begin : g_l0
                assign l_start = '0;
                assign l_bytes = '0;
                assign l_free  = 1'b0;
                assign l_valid = 1'b0;
            end else begin : g_ln
                assign l_start = c_start[g-1];
                assign l_bytes = c_bytes[g-1];
                assign l_free  = c_free[g-1];
                assign l_valid = c_valid[g-1];
            end
            if (g == MAX_BLOCKS - 1) begin : g_rl
                assign rt_start = '0;
                assign rt_bytes = '0;
                assign rt_free  = 1'b0;
                assign rt_valid = 1'b0;
            end else begin : g_rn
                assign rt_start = c_start[g+1];
                assign rt_bytes = c_bytes[g+1];
                assign rt_free  = c_free[g+1];
                assign rt_valid = c_valid[g+1];
            end
            ffba_cell #(
                .AW           (AW),
                .IW           (IW),
                .IDX          (g),
                .HEAP_BYTES   (HEAP_BYTES),
                .HEADER_BYTES (HEADER_BYTES)
            ) u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_cmd     (cmd),
                .i_idx     (cmd_idx),
                .i_sz      (r_sz),
                .i_tgt     (tgt_c),
                .i_tgt_ok  (tgt_ok_c),
                .i_l_start (l_start),
                .i_l_bytes (l_bytes),
                .i_l_free  (l_free),
                .i_l_valid (l_valid),
                .i_r_start (rt_start),
                .i_r_bytes (rt_bytes),
                .i_r_free  (rt_free),
                .i_r_valid (rt_valid),
                .o_start   (c_start[g]),
                .o_bytes   (c_bytes[g]),
                .o_free    (c_free[g]),
                .o_valid   (c_valid[g]),
                .o_fit     (c_fit[g]),
                .o_split   (c_split[g]),
                .o_hit     (c_hit[g])
            );
        end
    endgenerate

    assign o_out_valid = r_out_valid;
    assign o_address   = r_out_addr;
    assign o_status    = r_out_status;

endmodule

// ===== tb/sv/first_fit_block_allocator_core_tb.sv =====
// Self-checking bench for first_fit_block_allocator_core: directed table, fill and base-wrap
// runs, then random allocate/free traffic checked against a block-table predictor. Depends on ffba_pkg.
module first_fit_block_allocator_core_tb;

    localparam int HEAP  = ffba_pkg::HEAP_BYTES_DEF;
    localparam int MAXB  = ffba_pkg::MAX_BLOCKS_DEF;
    localparam int HDR   = ffba_pkg::HEADER_BYTES_DEF;
    localparam int WDOG  = 20000;

    typedef struct packed {
        logic                        mode;
        logic [ffba_pkg::SIZE_W-1:0] size;
        logic [ffba_pkg::ADDR_W-1:0] addr;
    } t_req;

    typedef struct packed {
        logic [ffba_pkg::ADDR_W-1:0] addr;
        ffba_pkg::t_status           status;
    } t_grant;

    typedef struct {
        t_req   req;
        logic   has_exp;
        t_grant exp;
    } t_row;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [ffba_pkg::ADDR_W-1:0]   i_cfg_data;
    logic                          i_in_valid;
    logic                          o_in_stall;
    logic                          i_mode;
    logic [ffba_pkg::SIZE_W-1:0]   i_request_size;
    logic [ffba_pkg::ADDR_W-1:0]   i_free_address;
    logic                          o_out_valid;
    logic                          i_out_stall;
    logic [ffba_pkg::ADDR_W-1:0]   o_address;
    logic [ffba_pkg::STATUS_W-1:0] o_status;

    first_fit_block_allocator_core dut (.*);

    logic [ffba_pkg::ADDR_W-1:0] base_q;
    logic [19:0]       blk_start [MAXB];
    logic [19:0]       blk_bytes [MAXB];
    logic              blk_free  [MAXB];
    int                blk_count;

    t_grant            grant_q [$];
    logic [ffba_pkg::ADDR_W-1:0] live_addrs [$];
    int                errors = 0;
    int                idle_cycles = 0;
    int                send_idle_pct;
    int                recv_idle_pct;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [ffba_pkg::ADDR_W-1:0] payload_of(int i);
        return base_q + ffba_pkg::ADDR_W'(blk_start[i]) + ffba_pkg::ADDR_W'(HDR);
    endfunction

    function automatic void table_reset();
        blk_count    = 1;
        blk_start[0] = '0;
        blk_bytes[0] = 20'(HEAP - HDR);
        blk_free[0]  = 1'b1;
    endfunction

    function automatic void drop_entry(int i);
        for (int j = i; j + 1 < blk_count; j++) begin
            blk_start[j] = blk_start[j+1];
            blk_bytes[j] = blk_bytes[j+1];
            blk_free[j]  = blk_free[j+1];
        end
        blk_count--;
    endfunction

    function automatic t_grant predict_grant(t_req r);
        t_grant g;
        logic [21:0] sz;
        int i;
        int j;
        g.addr   = '0;
        g.status = ffba_pkg::ST_NO_FIT;
        if (r.mode == 1'b0) begin
            if (r.size == 0) return g;
            sz = ({1'b0, r.size} + 22'd7) & ~22'd7;
            for (i = 0; i < blk_count; i++) begin
                if (blk_free[i] && {2'b0, blk_bytes[i]} >= sz) begin
                    if ({2'b0, blk_bytes[i]} > sz + HDR + 8 && blk_count < MAXB) begin
                        for (j = blk_count; j > i + 1; j--) begin
                            blk_start[j] = blk_start[j-1];
                            blk_bytes[j] = blk_bytes[j-1];
                            blk_free[j]  = blk_free[j-1];
                        end
                        blk_start[i+1] = blk_start[i] + 20'(HDR) + sz[19:0];
                        blk_bytes[i+1] = blk_bytes[i] - sz[19:0] - 20'(HDR);
                        blk_free[i+1]  = 1'b1;
                        blk_count++;
                        blk_bytes[i] = sz[19:0];
                    end
                    blk_free[i] = 1'b0;
                    g.addr   = payload_of(i);
                    g.status = ffba_pkg::ST_GRANTED;
                    return g;
                end
            end
            return g;
        end
        if (r.addr == 0) begin
            g.status = ffba_pkg::ST_NULL;
            return g;
        end
        for (i = 0; i < blk_count; i++) begin
            if (payload_of(i) == r.addr) begin
                blk_free[i] = 1'b1;
                j = 0;
                while (j + 1 < blk_count) begin
                    if (blk_free[j] && blk_free[j+1] &&
                        blk_start[j] + 20'(HDR) + blk_bytes[j] == blk_start[j+1]) begin
                        blk_bytes[j] = blk_bytes[j] + 20'(HDR) + blk_bytes[j+1];
                        drop_entry(j + 1);
                    end else begin
                        j++;
                    end
                end
                g.status = ffba_pkg::ST_FREED;
                return g;
            end
        end
        g.status = ffba_pkg::ST_UNKNOWN;
        return g;
    endfunction

    task automatic send_word(t_req r, logic has_exp, t_grant exp);
        t_grant g;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_mode         <= r.mode;
        i_request_size <= r.size;
        i_free_address <= r.addr;
        g = predict_grant(r);
        if (has_exp && g != exp) begin
            errors++;
            if (errors <= 10)
                $display("table row disagrees: typed %h/%0d predicted %h/%0d",
                         exp.addr, exp.status, g.addr, g.status);
        end
        grant_q.push_back(g);
        if (g.status == ffba_pkg::ST_GRANTED) live_addrs.push_back(g.addr);
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (grant_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_base(logic [ffba_pkg::ADDR_W-1:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        base_q = v;
    endtask

    function automatic t_req rand_req();
        t_req r;
        int k;
        r.mode = 1'b0;
        r.size = '0;
        r.addr = '0;
        k = $urandom_range(99);
        if (k < 45) begin
            r.size = ($urandom_range(9) == 0) ? ffba_pkg::SIZE_W'($urandom_range(1048576))
                                             : ffba_pkg::SIZE_W'($urandom_range(4096));
        end else if (k < 85 && live_addrs.size() != 0) begin
            r.mode = 1'b1;
            r.addr = live_addrs[$urandom_range(live_addrs.size() - 1)];
        end else if (k < 92) begin
            r.mode = 1'b1;
            r.addr = ffba_pkg::ADDR_W'({$urandom, $urandom});
            r.size = ffba_pkg::SIZE_W'($urandom);
        end else if (k < 96) begin
            r.mode = 1'b1;
            r.size = ffba_pkg::SIZE_W'($urandom);
        end else begin
            r.size = (k == 96) ? '1 : ffba_pkg::SIZE_W'($urandom_range(7));
            r.addr = ffba_pkg::ADDR_W'({$urandom, $urandom});
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
            if (o_out_valid && !i_out_stall) begin
                if (grant_q.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected word %h/%0d", o_address, o_status);
                end else begin
                    if (o_address !== grant_q[0].addr || o_status !== grant_q[0].status) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: expected %h/%0d got %h/%0d",
                                     grant_q[0].addr, grant_q[0].status, o_address, o_status);
                    end
                    void'(grant_q.pop_front());
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    t_row rows [$];

    function automatic void add_row(logic m, int sz, logic [ffba_pkg::ADDR_W-1:0] a,
                                    logic he, logic [ffba_pkg::ADDR_W-1:0] ea,
                                    ffba_pkg::t_status es);
        t_row w;
        w.req.mode = m;
        w.req.size = ffba_pkg::SIZE_W'(sz);
        w.req.addr = a;
        w.has_exp  = he;
        w.exp.addr = ea;
        w.exp.status = es;
        rows.push_back(w);
    endfunction

    initial begin
        t_grant none;
        none          = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        base_q        = ffba_pkg::BASE_RESET;
        table_reset();
        i_rst_n        <= 1'b0;
        i_cfg_valid    <= 1'b0;
        i_cfg_data     <= '0;
        i_in_valid     <= 1'b0;
        i_mode         <= 1'b0;
        i_request_size <= '0;
        i_free_address <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        add_row(0, 0, 0, 1, 0, ffba_pkg::ST_NO_FIT);
        add_row(1, 0, 0, 1, 0, ffba_pkg::ST_NULL);
        add_row(1, 5, 48'h123, 1, 0, ffba_pkg::ST_UNKNOWN);
        add_row(0, 1048576, 0, 1, 0, ffba_pkg::ST_NO_FIT);
        add_row(0, 1, 0, 1, 48'h400018, ffba_pkg::ST_GRANTED);
        add_row(0, 8, 0, 1, 48'h400038, ffba_pkg::ST_GRANTED);
        add_row(1, 0, 48'h400018, 1, 0, ffba_pkg::ST_FREED);
        add_row(1, 0, 48'h400018, 1, 0, ffba_pkg::ST_FREED);
        add_row(0, 3, 0, 0, 0, ffba_pkg::ST_GRANTED);
        add_row(0, 1048552, 0, 1, 0, ffba_pkg::ST_NO_FIT);
        add_row(0, 2097151, 0, 1, 0, ffba_pkg::ST_NO_FIT);
        add_row(1, 0, 48'hFFFF_FFFF_FFFF, 1, 0, ffba_pkg::ST_UNKNOWN);
        add_row(1, 0, 48'h400038, 0, 0, ffba_pkg::ST_FREED);
        add_row(1, 0, 48'h400018, 0, 0, ffba_pkg::ST_FREED);
        add_row(0, 1048552, 0, 1, 48'h400018, ffba_pkg::ST_GRANTED);
        add_row(1, 0, 48'h400018, 1, 0, ffba_pkg::ST_FREED);
        foreach (rows[n]) send_word(rows[n].req, rows[n].has_exp, rows[n].exp);
        drain();

        // fill the table so the no-split rule kicks in
        for (int n = 0; n < 70; n++)
            send_word('{1'b0, ffba_pkg::SIZE_W'(16), '0}, 1'b0, none);
        send_word('{1'b0, ffba_pkg::SIZE_W'(64), '0}, 1'b0, none);
        drain();
        live_addrs.delete();
        for (int n = 0; n < MAXB; n++)
            send_word('{1'b1, '0, base_q + 48'(HDR) + 48'(n * 40)}, 1'b0, none);
        drain();

        // wrap the payload address to zero, then extremes of the base
        write_base(48'h0 - 48'(HDR));
        send_word('{1'b0, ffba_pkg::SIZE_W'(8), '0}, 1'b1, '{48'h0, ffba_pkg::ST_GRANTED});
        send_word('{1'b1, '0, 48'h0}, 1'b1, '{48'h0, ffba_pkg::ST_NULL});
        drain();
        live_addrs.delete();

        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 23 : (ph == 1) ? 79 : 0;
            recv_idle_pct = (ph == 0) ? 79 : (ph == 1) ? 23 : 0;
            write_base((ph == 0) ? 48'hFFFF_FFFF_FFFF : (ph == 1) ? 48'h0
                                 : ffba_pkg::BASE_RESET);
            live_addrs.delete();
            for (int n = 0; n < 250; n++) send_word(rand_req(), 1'b0, none);
            drain();
        end

        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
